// File: sv/assert_macros.svh
// Assertion macros used by the checker file bfdh_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CHK_SAME(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("check failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define CHK_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("check failed: next-cycle implication");

`endif

// File: sv/bfdh_pkg.sv
// Shared constants, types and helper functions for the Bloom filter block.
// No dependencies.
package bfdh_pkg;

  localparam int MAX_BYTES   = 4096;
  localparam int ADDR_W      = $clog2(MAX_BYTES);
  localparam int SIZE_W      = 13;
  localparam int PROBE_W     = 6;
  localparam int HASH_W      = 32;
  localparam int MIN_SIZE    = 8;
  localparam int MAX_PROBES  = 32;
  localparam int ROT_RIGHT   = 17;
  localparam int BIT_SEL_W   = 3;
  localparam int RADIX_BITS  = 4;
  localparam int DIV_CYCLES  = HASH_W / RADIX_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);
  localparam int DATA_W      = 32;
  localparam int PADDR_W     = 3;

  typedef enum logic [0:0] {
    REG_SIZE   = 1'b0,
    REG_PROBES = 1'b1
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_DIV   = 5'b00100,
    S_READ  = 5'b01000,
    S_TEST  = 5'b10000
  } state_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic div;
    logic rd;
    logic test;
    logic advance;
    logic finish;
    logic match;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic bit_set;
    logic last_probe;
    logic zero_probes;
    logic is_query;
  } dp_stat_t;

  function automatic logic [SIZE_W-1:0] eff_bytes(input logic [SIZE_W-1:0] sz);
    logic [SIZE_W-1:0] r;
    r = sz;
    if (sz < SIZE_W'(MIN_SIZE)) r = SIZE_W'(MIN_SIZE);
    if (sz > SIZE_W'(MAX_BYTES)) r = SIZE_W'(MAX_BYTES);
    return r;
  endfunction

  function automatic logic [PROBE_W-1:0] eff_probes(input logic [PROBE_W-1:0] p);
    return (p > PROBE_W'(MAX_PROBES)) ? PROBE_W'(MAX_PROBES) : p;
  endfunction

endpackage

// File: sv/bfdh_dp.sv
// Datapath: probe hash registers, radix-16 serial modulo unit, bit store memory.
// Depends on bfdh_pkg.
module bfdh_dp import bfdh_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  ctrl_cmd_t           cmd,
  output dp_stat_t            stat,
  input  logic                req_type,
  input  logic [HASH_W-1:0]   key_hash,
  input  logic [SIZE_W-1:0]   size_eff,
  input  logic [PROBE_W-1:0]  probes_eff,
  output logic                done,
  output logic                may_match
);

  logic [HASH_W-1:0]    h;
  logic [HASH_W-1:0]    step;
  logic [HASH_W-1:0]    h_adv;
  logic                 is_query;
  logic [PROBE_W-1:0]   left;
  logic [HASH_W-1:0]    dq;
  logic [HASH_W-1:0]    dq_next;
  logic [SIZE_W-1:0]    rem;
  logic [SIZE_W-1:0]    rem_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [ADDR_W-1:0]    clr_addr;
  logic [7:0]           rd_data;
  logic [7:0]           mask;
  logic [7:0]           mem [MAX_BYTES];

  // pos mod (8*n) = ((pos >> 3) mod n) * 8 + pos[2:0]; divide pos >> 3 by n
  always_comb begin
    logic [SIZE_W:0]    t;
    logic [SIZE_W-1:0]  r;
    logic [HASH_W-1:0]  q;
    r = rem;
    q = dq;
    for (int i = 0; i < RADIX_BITS; i++) begin
      t = {r, q[HASH_W-1]};
      if (t >= {1'b0, size_eff}) t = t - {1'b0, size_eff};
      r = t[SIZE_W-1:0];
      q = {q[HASH_W-2:0], 1'b0};
    end
    rem_next = r;
    dq_next  = q;
  end

  assign h_adv = h + step;
  assign mask  = 8'(1) << h[BIT_SEL_W-1:0];

  assign stat.clr_last    = &clr_addr;
  assign stat.div_last    = (div_cnt == DIV_CNT_W'(DIV_CYCLES - 1));
  assign stat.bit_set     = rd_data[h[BIT_SEL_W-1:0]];
  assign stat.last_probe  = (left == PROBE_W'(1));
  assign stat.zero_probes = (probes_eff == '0);
  assign stat.is_query    = is_query;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      h        <= key_hash;
      step     <= {key_hash[ROT_RIGHT-1:0], key_hash[HASH_W-1:ROT_RIGHT]};
      is_query <= req_type;
      left     <= probes_eff;
      dq       <= {{BIT_SEL_W{1'b0}}, key_hash[HASH_W-1:BIT_SEL_W]};
      rem      <= '0;
      div_cnt  <= '0;
    end else if (cmd.advance) begin
      h        <= h_adv;
      left     <= left - PROBE_W'(1);
      dq       <= {{BIT_SEL_W{1'b0}}, h_adv[HASH_W-1:BIT_SEL_W]};
      rem      <= '0;
      div_cnt  <= '0;
    end else if (cmd.div) begin
      dq      <= dq_next;
      rem     <= rem_next;
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  // remainder is below size_eff <= MAX_BYTES, so it fits the address
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      mem[clr_addr] <= '0;
    end else if (cmd.test && !is_query) begin
      mem[rem[ADDR_W-1:0]] <= rd_data | mask;
    end
    if (cmd.rd) begin
      rd_data <= mem[rem[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      if (cmd.clr) clr_addr <= clr_addr + ADDR_W'(1);
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) may_match <= cmd.match;
  end

endmodule

// File: sv/bfdh_ctrl.sv
// Controller: sequences clear pass, per-probe divide, read and test steps.
// Depends on bfdh_pkg.
module bfdh_ctrl import bfdh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      req_type,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd,
  output logic      busy
);

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (stat.zero_probes) begin
            // nothing to probe: a query trivially matches
            cmd.finish = req_type;
            cmd.match  = 1'b1;
          end else begin
            state_next = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (stat.div_last) state_next = S_READ;
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_TEST;
      end
      S_TEST: begin
        cmd.test = 1'b1;
        if (stat.is_query && !stat.bit_set) begin
          cmd.finish = 1'b1;
          cmd.match  = 1'b0;
          state_next = S_IDLE;
        end else if (stat.last_probe) begin
          cmd.finish = stat.is_query;
          cmd.match  = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_DIV;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: sv/bloom_filter_double_hash.sv
// channel   direction  handshake                   payload
// item      in         start & !busy               req_type, key_hash
// result    out        done (one-cycle strobe)     may_match
// config    in         psel&penable&pwrite&pready  paddr, pwdata (prdata on read)
//
// After reset a clearing pass zeroes the bit store byte by byte, with busy high.
// An item is accepted in idle; each of its P probes, P the effective probe count,
// is a radix-16 serial modulo, one memory read and one test/write step. A query
// ends at the first clear bit; zero probes end in the accept cycle.
// done follows the last cycle of a query (adds raise no done); the receiver cannot stall it.
// Top level: configuration registers, controller and datapath.
// Depends on bfdh_pkg, bfdh_ctrl, bfdh_dp.
module bloom_filter_double_hash import bfdh_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               req_type,
  input  logic [HASH_W-1:0]  key_hash,
  output logic               done,
  output logic               may_match,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  logic [SIZE_W-1:0]  size_bytes;
  logic [PROBE_W-1:0] probe_count;
  logic               wr_en;
  reg_idx_t           reg_sel;
  ctrl_cmd_t          cmd;
  dp_stat_t           stat;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      size_bytes  <= SIZE_W'(512);
      probe_count <= PROBE_W'(6);
    end else if (wr_en) begin
      case (reg_sel)
        REG_SIZE:   size_bytes  <= pwdata[SIZE_W-1:0];
        REG_PROBES: probe_count <= pwdata[PROBE_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SIZE:   prdata = DATA_W'(size_bytes);
      REG_PROBES: prdata = DATA_W'(probe_count);
      default:    prdata = '0;
    endcase
  end

  bfdh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  bfdh_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req_type   (req_type),
    .key_hash   (key_hash),
    .size_eff   (eff_bytes(size_bytes)),
    .probes_eff (eff_probes(probe_count)),
    .done       (done),
    .may_match  (may_match)
  );

endmodule

// File: sv/bfdh_checker.sv
// Port-level checks on the Bloom filter top level, attached by bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module bfdh_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic req_type,
  input logic done
);

  // a result beat only ever lands with the block back at idle
  `CHK_SAME(a_done_idle, clk, rst, done, !busy)
  // an accepted add never produces a result beat; checked right after acceptance
  `CHK_NEXT(a_add_silent, clk, rst, start && !busy && !req_type, !done)
  // a result beat needs work in flight or an accept just before it
  `CHK_SAME(a_done_cause, clk, rst, done, $past(busy || start))
  // leaving reset starts the clearing pass
  `CHK_SAME(a_clear_busy, clk, rst, $past(rst), busy)

endmodule

bind bloom_filter_double_hash bfdh_checker u_bfdh_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .req_type (req_type),
  .done     (done)
);
